>>> rtl/length_prefixed_frame_checker_core_assert.svh
// Assertion macros shared by the frame checker's assertion files.
// Each macro samples on clock and is disabled while reset is high.
`ifndef LENGTH_PREFIXED_FRAME_CHECKER_CORE_ASSERT_SVH
`define LENGTH_PREFIXED_FRAME_CHECKER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LPFC_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("frame checker assertion failed (same cycle)");

// Consequent must hold in the cycle after the antecedent.
`define LPFC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("frame checker assertion failed (next cycle)");

`endif

>>> rtl/lpfc_pkg.sv
// Package for the length-prefixed frame checker: widths, reset values,
// CRC constants, event codes and register indexes. No dependencies.
package lpfc_pkg;

   localparam int BYTE_WIDTH      = 8;
   localparam int LENGTH_WIDTH    = 16;
   localparam int CRC_WIDTH       = 16;
   localparam int POS_WIDTH       = 17;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int OUT_COUNT_WIDTH = 32;

   localparam logic [CRC_WIDTH-1:0] CRC_POLY = 16'h1021;
   localparam logic [CRC_WIDTH-1:0] CRC_TOP  = 16'h8000;

   localparam logic [BYTE_WIDTH-1:0]   START_MARKER_RESET = 8'd50;
   localparam logic [BYTE_WIDTH-1:0]   END_MARKER_RESET   = 8'd52;
   localparam logic [LENGTH_WIDTH-1:0] MIN_LENGTH_RESET   = 16'd14;
   localparam logic [LENGTH_WIDTH-1:0] MAX_LENGTH_RESET   = 16'd1500;

   typedef enum logic [1:0] {
      EVENT_GOOD        = 2'd0,
      EVENT_BAD         = 2'd1,
      EVENT_SIZE_REJECT = 2'd2
   } event_kind_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_START_MARKER = 2'd0,
      CSR_END_MARKER   = 2'd1,
      CSR_MIN_LENGTH   = 2'd2,
      CSR_MAX_LENGTH   = 2'd3
   } csr_index_type;

endpackage

>>> rtl/lpfc_crc_byte.sv
// One-byte update of CRC-16 (polynomial 0x1021, MSB first, no reflection).
// Depends on lpfc_pkg for widths and the polynomial.
module lpfc_crc_byte
   import lpfc_pkg::*;
(
   input  logic [CRC_WIDTH-1:0]  crc_cur,
   input  logic [BYTE_WIDTH-1:0] data_byte,
   output logic [CRC_WIDTH-1:0]  crc_next
);

   always_comb begin
      logic [CRC_WIDTH-1:0] acc;
      acc = crc_cur ^ {data_byte, {(CRC_WIDTH-BYTE_WIDTH){1'b0}}};
      for (int i = 0; i < BYTE_WIDTH; i++) begin
         if ((acc & CRC_TOP) != '0) begin
            acc = (acc << 1) ^ CRC_POLY;
         end else begin
            acc = acc << 1;
         end
      end
      crc_next = acc;
   end

endmodule

>>> rtl/length_prefixed_frame_checker_core.sv
// Length-prefixed frame checker, top level.
// Depends on lpfc_pkg and lpfc_crc_byte.
//
// Usage: received bytes enter one per request on the req_ channel. The block
// hunts for the start marker, reads a big-endian 16-bit size S, rejects sizes
// outside [min_length, max_length] and otherwise runs a CRC-16/XMODEM over
// positions 3 to S-2, compares it with the CRC carried at positions S-1 and S
// and checks the end marker at position S+1. Each finished or rejected frame
// yields one request on the rsp_ channel with the check results and the
// wrapping total, good and bad frame counters; other bytes yield nothing.
// An accepted byte waits in the input register until it is processed, and
// its result, if any, is then loaded into the result register. Throughput:
// one byte per cycle while rsp_ is not stalled, set by the combinational CRC
// byte update and size compares between the input and result registers.
// When the receiver stalls rsp_, the result register holds its request; the
// byte in the input register then waits and req_stall rises, so no result is
// lost. Reset is synchronous: it empties both registers, clears the frame state
// and counters, and loads the default marker and size registers. The user writes
// registers through csr_ only while the block is idle; the block does not enforce it.
module length_prefixed_frame_checker_core
   import lpfc_pkg::*;
#(
   parameter int COUNT_WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   // Configuration write port.
   input  logic                       csr_write_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data,
   // Byte input channel.
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [BYTE_WIDTH-1:0]      req_rx_byte,
   // Result channel.
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [1:0]                 rsp_event_kind,
   output logic [LENGTH_WIDTH-1:0]    rsp_frame_length,
   output logic [CRC_WIDTH-1:0]       rsp_computed_crc,
   output logic [CRC_WIDTH-1:0]       rsp_received_crc,
   output logic                       rsp_end_ok,
   output logic [OUT_COUNT_WIDTH-1:0] rsp_total_frames,
   output logic [OUT_COUNT_WIDTH-1:0] rsp_good_frames,
   output logic [OUT_COUNT_WIDTH-1:0] rsp_bad_frames
);

   // Counters are reported as their low 32 bits, zero-extended when narrower.
   localparam int EXT_WIDTH =
      (COUNT_WIDTH > OUT_COUNT_WIDTH) ? COUNT_WIDTH : OUT_COUNT_WIDTH;

   // Configuration registers.
   logic [BYTE_WIDTH-1:0]   start_marker_ff;
   logic [BYTE_WIDTH-1:0]   end_marker_ff;
   logic [LENGTH_WIDTH-1:0] min_length_ff;
   logic [LENGTH_WIDTH-1:0] max_length_ff;

   // Input register.
   logic                  in_valid_ff, in_valid_in;
   logic [BYTE_WIDTH-1:0] in_byte_ff;

   // Frame state.
   logic [POS_WIDTH-1:0]    position_ff, position_in;
   logic [LENGTH_WIDTH-1:0] length_ff, length_in;
   logic [CRC_WIDTH-1:0]    running_crc_ff, running_crc_in;
   logic [CRC_WIDTH-1:0]    frame_crc_ff, frame_crc_in;
   logic                    end_hit_ff, end_hit_in;
   logic [BYTE_WIDTH-1:0]   start_byte_ff, start_byte_in;
   logic [COUNT_WIDTH-1:0]  total_ff, total_in;
   logic [COUNT_WIDTH-1:0]  good_ff, good_in;
   logic [COUNT_WIDTH-1:0]  bad_ff, bad_in;

   // Result register.
   logic                       rsp_valid_ff, rsp_valid_in;
   event_kind_type             rsp_kind_ff, rsp_kind_in;
   logic [LENGTH_WIDTH-1:0]    rsp_length_ff, rsp_length_in;
   logic [CRC_WIDTH-1:0]       rsp_ccrc_ff, rsp_ccrc_in;
   logic [CRC_WIDTH-1:0]       rsp_rcrc_ff, rsp_rcrc_in;
   logic                       rsp_end_ok_ff, rsp_end_ok_in;
   logic [OUT_COUNT_WIDTH-1:0] rsp_total_ff, rsp_good_ff, rsp_bad_ff;
   logic [EXT_WIDTH-1:0]       total_ext, good_ext, bad_ext;

   // Handshake control.
   logic out_free;
   logic advance;
   logic req_accept;
   logic emit;
   logic emit_go;

   logic [CRC_WIDTH-1:0] crc_step;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign advance    = in_valid_ff && out_free;
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;
   assign emit_go    = advance && emit;

   lpfc_crc_byte u_crc_byte (
      .crc_cur   (running_crc_ff),
      .data_byte (in_byte_ff),
      .crc_next  (crc_step)
   );

   // Frame tracking: one byte per pass, result fields computed alongside.
   always_comb begin
      logic [BYTE_WIDTH-1:0]   b;
      logic [LENGTH_WIDTH-1:0] len;
      logic [POS_WIDTH-1:0]    len_ext;
      logic                    complete;
      logic                    good;
      b        = in_byte_ff;
      len      = {length_ff[LENGTH_WIDTH-1:BYTE_WIDTH], in_byte_ff};
      len_ext  = {1'b0, length_ff};
      complete = 1'b0;
      good     = 1'b0;

      position_in    = position_ff;
      length_in      = length_ff;
      running_crc_in = running_crc_ff;
      frame_crc_in   = frame_crc_ff;
      end_hit_in     = end_hit_ff;
      start_byte_in  = start_byte_ff;
      total_in       = total_ff;
      good_in        = good_ff;
      bad_in         = bad_ff;

      emit          = 1'b0;
      rsp_kind_in   = EVENT_SIZE_REJECT;
      rsp_length_in = length_ff;
      rsp_ccrc_in   = '0;
      rsp_rcrc_in   = '0;
      rsp_end_ok_in = 1'b0;

      priority if (position_ff == POS_WIDTH'(0)) begin
         // Hunting: only the start marker opens a frame.
         if (b == start_marker_ff) begin
            start_byte_in  = b;
            position_in    = POS_WIDTH'(1);
            length_in      = '0;
            running_crc_in = '0;
            frame_crc_in   = '0;
            end_hit_in     = 1'b0;
         end
      end else if (position_ff == POS_WIDTH'(1)) begin
         length_in   = {b, {BYTE_WIDTH{1'b0}}};
         position_in = POS_WIDTH'(2);
      end else if (position_ff == POS_WIDTH'(2)) begin
         length_in = len;
         if (len < min_length_ff || len > max_length_ff) begin
            emit          = 1'b1;
            rsp_kind_in   = EVENT_SIZE_REJECT;
            rsp_length_in = len;
            position_in   = '0;
            length_in     = '0;
            start_byte_in = '0;
         end else begin
            // Tiny sizes place CRC or end checks on the header bytes.
            frame_crc_in = '0;
            end_hit_in   = 1'b0;
            unique case (len)
               LENGTH_WIDTH'(0): begin
                  frame_crc_in = {{BYTE_WIDTH{1'b0}}, start_byte_ff};
                  end_hit_in   = (length_ff[LENGTH_WIDTH-1:BYTE_WIDTH] == end_marker_ff);
               end
               LENGTH_WIDTH'(1): begin
                  frame_crc_in = {start_byte_ff, length_ff[LENGTH_WIDTH-1:BYTE_WIDTH]};
                  end_hit_in   = (b == end_marker_ff);
               end
               LENGTH_WIDTH'(2): begin
                  frame_crc_in = {length_ff[LENGTH_WIDTH-1:BYTE_WIDTH], b};
               end
               LENGTH_WIDTH'(3): begin
                  frame_crc_in = {b, {BYTE_WIDTH{1'b0}}};
               end
               default: begin
                  frame_crc_in = '0;
               end
            endcase
            position_in = POS_WIDTH'(3);
            complete    = (len <= LENGTH_WIDTH'(1));
         end
      end else begin
         // Body, CRC and end marker bytes.
         if (position_ff + POS_WIDTH'(2) <= len_ext) begin
            running_crc_in = crc_step;
         end
         if (position_ff + POS_WIDTH'(1) == len_ext) begin
            frame_crc_in[CRC_WIDTH-1:BYTE_WIDTH] = b;
         end
         if (position_ff == len_ext) begin
            frame_crc_in[BYTE_WIDTH-1:0] = b;
         end
         if (position_ff == len_ext + POS_WIDTH'(1)) begin
            end_hit_in = (b == end_marker_ff);
         end
         position_in = position_ff + POS_WIDTH'(1);
         complete    = (position_ff >= len_ext + POS_WIDTH'(1));
      end

      if (complete) begin
         good     = end_hit_in && (running_crc_in == frame_crc_in);
         total_in = total_ff + COUNT_WIDTH'(1);
         if (good) begin
            good_in = good_ff + COUNT_WIDTH'(1);
         end else begin
            bad_in = bad_ff + COUNT_WIDTH'(1);
         end
         emit          = 1'b1;
         rsp_kind_in   = good ? EVENT_GOOD : EVENT_BAD;
         rsp_length_in = length_in;
         rsp_ccrc_in   = running_crc_in;
         rsp_rcrc_in   = frame_crc_in;
         rsp_end_ok_in = end_hit_in;
         // Back to hunting with a clean frame context.
         position_in    = '0;
         length_in      = '0;
         running_crc_in = '0;
         frame_crc_in   = '0;
         end_hit_in     = 1'b0;
         start_byte_in  = '0;
      end
   end

   assign total_ext = EXT_WIDTH'(total_in);
   assign good_ext  = EXT_WIDTH'(good_in);
   assign bad_ext   = EXT_WIDTH'(bad_in);

   // The input register fills on accept and drains when the byte is processed.
   always_comb begin
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   // The result register loads on a new event and empties once taken.
   always_comb begin
      if (emit_go) begin
         rsp_valid_in = 1'b1;
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff <= START_MARKER_RESET;
         end_marker_ff   <= END_MARKER_RESET;
         min_length_ff   <= MIN_LENGTH_RESET;
         max_length_ff   <= MAX_LENGTH_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_START_MARKER: start_marker_ff <= csr_write_data[BYTE_WIDTH-1:0];
            CSR_END_MARKER:   end_marker_ff   <= csr_write_data[BYTE_WIDTH-1:0];
            CSR_MIN_LENGTH:   min_length_ff   <= csr_write_data;
            CSR_MAX_LENGTH:   max_length_ff   <= csr_write_data;
            default:          start_marker_ff <= start_marker_ff;
         endcase
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   // Frame state and counters advance once per processed byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff    <= '0;
         length_ff      <= '0;
         running_crc_ff <= '0;
         frame_crc_ff   <= '0;
         end_hit_ff     <= 1'b0;
         start_byte_ff  <= '0;
         total_ff       <= '0;
         good_ff        <= '0;
         bad_ff         <= '0;
      end else if (advance) begin
         position_ff    <= position_in;
         length_ff      <= length_in;
         running_crc_ff <= running_crc_in;
         frame_crc_ff   <= frame_crc_in;
         end_hit_ff     <= end_hit_in;
         start_byte_ff  <= start_byte_in;
         total_ff       <= total_in;
         good_ff        <= good_in;
         bad_ff         <= bad_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_go) begin
         rsp_kind_ff   <= rsp_kind_in;
         rsp_length_ff <= rsp_length_in;
         rsp_ccrc_ff   <= rsp_ccrc_in;
         rsp_rcrc_ff   <= rsp_rcrc_in;
         rsp_end_ok_ff <= rsp_end_ok_in;
         rsp_total_ff  <= total_ext[OUT_COUNT_WIDTH-1:0];
         rsp_good_ff   <= good_ext[OUT_COUNT_WIDTH-1:0];
         rsp_bad_ff    <= bad_ext[OUT_COUNT_WIDTH-1:0];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_kind   = rsp_kind_ff;
   assign rsp_frame_length = rsp_length_ff;
   assign rsp_computed_crc = rsp_ccrc_ff;
   assign rsp_received_crc = rsp_rcrc_ff;
   assign rsp_end_ok       = rsp_end_ok_ff;
   assign rsp_total_frames = rsp_total_ff;
   assign rsp_good_frames  = rsp_good_ff;
   assign rsp_bad_frames   = rsp_bad_ff;

endmodule

>>> rtl/lpfc_checker.sv
// Port-level assertions for the frame checker, bound to its top level.
// Depends on lpfc_pkg and length_prefixed_frame_checker_core_assert.svh.
`include "length_prefixed_frame_checker_core_assert.svh"

module lpfc_checker
   import lpfc_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic [1:0]              rsp_event_kind,
   input logic [LENGTH_WIDTH-1:0] rsp_frame_length,
   input logic [CRC_WIDTH-1:0]    rsp_computed_crc,
   input logic [CRC_WIDTH-1:0]    rsp_received_crc,
   input logic                    rsp_end_ok
);

   // A stalled result stays offered, with its kind, length and CRC fields unchanged.
   `LPFC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_event_kind) && $stable(rsp_frame_length) && $stable(rsp_computed_crc) && $stable(rsp_received_crc))

   // A rejected size carries no check results.
   `LPFC_ASSERT_SAME(a_reject_clean, rsp_valid && rsp_event_kind == EVENT_SIZE_REJECT, rsp_computed_crc == '0 && rsp_received_crc == '0 && !rsp_end_ok)

   // A good frame passed both checks.
   `LPFC_ASSERT_SAME(a_good_checks, rsp_valid && rsp_event_kind == EVENT_GOOD, rsp_end_ok && rsp_computed_crc == rsp_received_crc)

   // A bad frame failed at least one check.
   `LPFC_ASSERT_SAME(a_bad_checks, rsp_valid && rsp_event_kind == EVENT_BAD, !rsp_end_ok || rsp_computed_crc != rsp_received_crc)

endmodule

bind length_prefixed_frame_checker_core lpfc_checker u_lpfc_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_event_kind   (rsp_event_kind),
   .rsp_frame_length (rsp_frame_length),
   .rsp_computed_crc (rsp_computed_crc),
   .rsp_received_crc (rsp_received_crc),
   .rsp_end_ok       (rsp_end_ok)
);
